FILE: design/mpvp_pkg.sv
package mpvp_pkg;

  localparam int MAX_DIM_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_MAT   = 2'd0,
    OP_VEC   = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Matrix-multiply source/destination selection for the datapath.
  typedef enum logic [1:0] {
    MM_ACC_POW = 2'd0,  // acc = acc * pow
    MM_POW_POW = 2'd1,  // pow = pow * pow
    MM_ACC_VEC = 2'd2,  // out = acc * v
    MM_INIT    = 2'd3   // pow = base, acc = identity
  } mm_sel_t;

  typedef struct packed {
    logic    go;
    mm_sel_t sel;
  } mpvp_cmd_t;

  typedef struct packed {
    logic done;
  } mpvp_sts_t;

endpackage

FILE: design/mpvp_if.sv
interface mpvp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [4:0]  row_index;
  logic [4:0]  col_index;
  logic signed [31:0] value;
  logic [31:0] exponent;
  modport source (output valid, operation, row_index, col_index, value, exponent,
                  input ready);
  modport sink (input valid, operation, row_index, col_index, value, exponent,
                output ready);
endinterface

interface mpvp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  row_index_res;
  logic signed [31:0] result_value;
  logic        last;
  modport source (output valid, row_index_res, result_value, last, input ready);
  modport sink (input valid, row_index_res, result_value, last, output ready);
endinterface

FILE: design/mpvp_ctrl.sv
module mpvp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         exponent,
  input  mpvp_pkg::mpvp_sts_t sts,
  output mpvp_pkg::mpvp_cmd_t cmd,
  output logic                busy
);
  import mpvp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INIT = 5'b00010,
    S_MUL  = 5'b00100,
    S_SQR  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic        wait_r, wait_nxt;

  always_comb begin
    state_nxt = state_r;
    exp_nxt   = exp_r;
    wait_nxt  = wait_r;
    cmd.go    = 1'b0;
    cmd.sel   = MM_INIT;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          exp_nxt   = exponent;
          state_nxt = S_INIT;
          wait_nxt  = 1'b0;
        end
      end
      S_INIT: begin
        cmd.sel = MM_INIT;
        if (!wait_r) begin
          cmd.go = 1'b1;
          wait_nxt = 1'b1;
        end else if (sts.done) begin
          wait_nxt = 1'b0;
          state_nxt = (exp_r == '0) ? S_OUT : (exp_r[0] ? S_MUL : S_SQR);
        end
      end
      S_MUL: begin
        cmd.sel = MM_ACC_POW;
        if (!wait_r) begin
          cmd.go = 1'b1;
          wait_nxt = 1'b1;
        end else if (sts.done) begin
          wait_nxt = 1'b0;
          state_nxt = (exp_r[31:1] == '0) ? S_OUT : S_SQR;
        end
      end
      S_SQR: begin
        cmd.sel = MM_POW_POW;
        if (!wait_r) begin
          cmd.go = 1'b1;
          wait_nxt = 1'b1;
        end else if (sts.done) begin
          wait_nxt = 1'b0;
          exp_nxt = {1'b0, exp_r[31:1]};
          state_nxt = exp_r[1] ? S_MUL : S_SQR;
        end
      end
      S_OUT: begin
        cmd.sel = MM_ACC_VEC;
        if (!wait_r) begin
          cmd.go = 1'b1;
          wait_nxt = 1'b1;
        end else if (sts.done) begin
          wait_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      exp_r   <= '0;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      exp_r   <= exp_nxt;
      wait_r  <= wait_nxt;
    end
  end
endmodule

FILE: design/mpvp_dp.sv
module mpvp_dp #(
  parameter int MAX_DIM   = mpvp_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mpvp_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_mat,
  input  logic                wr_vec,
  input  logic [4:0]          wr_row,
  input  logic [4:0]          wr_col,
  input  logic [31:0]         wr_val,
  input  logic [5:0]          size,
  input  mpvp_pkg::mpvp_cmd_t cmd,
  output mpvp_pkg::mpvp_sts_t sts,
  output logic                o_valid,
  input  logic                o_ready,
  output logic [4:0]          o_row,
  output logic [31:0]         o_val,
  output logic                o_last
);
  import mpvp_pkg::*;

  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int NMAX = (MAX_DIM < 32) ? MAX_DIM : 32;
  localparam int AccW = 2 * 32 + IW + 1;

  logic [31:0] base_mem [DEPTH];
  logic [31:0] pow_mem  [DEPTH];
  logic [31:0] acc_mem  [DEPTH];
  logic [31:0] tmp_mem  [DEPTH];
  logic [31:0] vec_mem  [MAX_DIM];

  // Phases: run products into tmp, drain, then copy tmp back; init copies base, the vector product streams out.
  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_RUN  = 4'b0010,
    P_COPY = 4'b0100,
    P_OUT  = 4'b1000
  } ph_t;

  ph_t     ph_r;
  mm_sel_t sel_r;
  logic [IW:0] n_eff;
  logic [IW-1:0] i_r, j_r, k_r;
  logic [IW-1:0] ci_r, cj_r;
  logic          rd_v_r, rd_last_r, mul_v_r, mul_last_r, mul_first_r, rd_first_r;
  logic [IW-1:0] rd_i_r, rd_j_r, mul_i_r, mul_j_r;
  logic [31:0]   xa_r, yb_r;
  logic signed [63:0] prod_r;
  logic signed [AccW-1:0] acc_r;
  logic          res_v_r;
  logic [IW-1:0] res_i_r, res_j_r;
  logic [31:0]   sat_val;
  logic          stall;
  logic [IW-1:0] cnt_last;
  logic          issue;
  logic          drained;
  logic [31:0]   cp_r;
  logic          cp_v_r;
  logic [IW-1:0] cpi_r, cpj_r;
  logic          done_r;

  always_comb begin
    if (size == '0) n_eff = (IW+1)'(1);
    else if ({1'b0, size} > 7'(NMAX)) n_eff = (IW+1)'(NMAX);
    else n_eff = (IW+1)'(size);
  end
  assign cnt_last = IW'(n_eff - 1'b1);

  // Output backpressure holds the whole product pipeline in the vector phase.
  assign stall = (sel_r == MM_ACC_VEC) && o_valid && !o_ready;
  assign issue = (ph_r == P_RUN) && !stall;
  assign drained = !rd_v_r && !mul_v_r && !res_v_r && !(o_valid && !o_ready);

  logic [AW-1:0] wa;
  assign wa = {IW'(wr_row), IW'(wr_col)};

  logic wr_ok_r, wr_ok_c;
  assign wr_ok_r = (32'(wr_row) < 32'(MAX_DIM));
  assign wr_ok_c = (32'(wr_col) < 32'(MAX_DIM));

  always_ff @(posedge clk) begin
    if (wr_mat && wr_ok_r && wr_ok_c) base_mem[wa] <= wr_val;
    if (wr_vec && wr_ok_r) vec_mem[IW'(wr_row)] <= wr_val;
  end

  // Operand reads, registered.
  logic [AW-1:0] xa_addr, yb_addr;
  assign xa_addr = {i_r, k_r};
  assign yb_addr = {k_r, j_r};

  always_ff @(posedge clk) begin
    if (!stall) begin
      case (sel_r)
        MM_ACC_POW: begin
          xa_r <= acc_mem[xa_addr];
          yb_r <= pow_mem[yb_addr];
        end
        MM_POW_POW: begin
          xa_r <= pow_mem[xa_addr];
          yb_r <= pow_mem[yb_addr];
        end
        MM_ACC_VEC: begin
          xa_r <= acc_mem[xa_addr];
          yb_r <= vec_mem[k_r];
        end
        default: begin
          xa_r <= base_mem[xa_addr];
          yb_r <= '0;
        end
      endcase
      prod_r <= $signed(xa_r) * $signed(yb_r);
      if (mul_v_r) begin
        acc_r <= (mul_first_r ? '0 : acc_r) + AccW'(prod_r);
      end
    end
  end

  // Shift and saturate.
  always_comb begin
    logic signed [AccW-1:0] sh;
    sh = acc_r >>> FRAC_BITS;
    if (sh > AccW'(64'sh7FFF_FFFF)) sat_val = 32'h7FFF_FFFF;
    else if (sh < -AccW'(64'sh8000_0000)) sat_val = 32'h8000_0000;
    else sat_val = sh[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE;
      sel_r <= MM_INIT;
      rd_v_r <= 1'b0;
      mul_v_r <= 1'b0;
      res_v_r <= 1'b0;
      cp_v_r <= 1'b0;
      o_valid <= 1'b0;
      done_r <= 1'b0;
      i_r <= '0; j_r <= '0; k_r <= '0; ci_r <= '0; cj_r <= '0;
    end else begin
      if (!stall && res_v_r && (sel_r == MM_ACC_VEC)) o_valid <= 1'b1;
      else if (o_valid && o_ready) o_valid <= 1'b0;
      if (!stall) begin
        rd_v_r <= issue;
        rd_last_r <= (k_r == cnt_last);
        rd_first_r <= (k_r == '0);
        rd_i_r <= i_r;
        rd_j_r <= j_r;
        mul_v_r <= rd_v_r;
        mul_last_r <= rd_last_r;
        mul_first_r <= rd_first_r;
        mul_i_r <= rd_i_r;
        mul_j_r <= rd_j_r;
        res_v_r <= mul_v_r && mul_last_r;
        res_i_r <= mul_i_r;
        res_j_r <= mul_j_r;
        if (res_v_r) begin
          if (sel_r == MM_ACC_VEC) begin
            o_row <= 5'(res_i_r);
            o_val <= sat_val;
            o_last <= (res_i_r == cnt_last);
          end else begin
            tmp_mem[{res_i_r, res_j_r}] <= sat_val;
          end
        end
      end
      case (ph_r)
        P_IDLE: begin
          if (cmd.go) begin
            sel_r <= cmd.sel;
            i_r <= '0; j_r <= '0; k_r <= '0; ci_r <= '0; cj_r <= '0;
            ph_r <= (cmd.sel == MM_INIT) ? P_COPY : P_RUN;
          end
        end
        P_RUN: begin
          if (!stall) begin
            if (k_r == cnt_last) begin
              k_r <= '0;
              if ((sel_r == MM_ACC_VEC) || (j_r == cnt_last)) begin
                j_r <= '0;
                if (i_r == cnt_last) ph_r <= P_OUT;
                else i_r <= i_r + 1'b1;
              end else j_r <= j_r + 1'b1;
            end else k_r <= k_r + 1'b1;
          end
        end
        P_OUT: begin
          // Drain the pipeline, then copy (or finish, for the vector product).
          if (drained) begin
            if (sel_r == MM_ACC_VEC) ph_r <= P_IDLE;
            else ph_r <= P_COPY;
          end
        end
        P_COPY: begin
          if (cj_r == cnt_last) begin
            cj_r <= '0;
            if (ci_r == cnt_last) begin
              ph_r <= P_IDLE;
            end else ci_r <= ci_r + 1'b1;
          end else cj_r <= cj_r + 1'b1;
        end
        default: ph_r <= P_IDLE;
      endcase
      cp_v_r <= (ph_r == P_COPY);
      cpi_r <= ci_r;
      cpj_r <= cj_r;
      if (sel_r == MM_INIT) cp_r <= base_mem[{ci_r, cj_r}];
      else cp_r <= tmp_mem[{ci_r, cj_r}];
      done_r <= ((ph_r == P_OUT) && drained && (sel_r == MM_ACC_VEC)) ||
                (cp_v_r && (ph_r != P_COPY));
    end
  end

  always_ff @(posedge clk) begin
    if (cp_v_r) begin
      case (sel_r)
        MM_INIT: begin
          pow_mem[{cpi_r, cpj_r}] <= cp_r;
          acc_mem[{cpi_r, cpj_r}] <= (cpi_r == cpj_r) ? (32'd1 << FRAC_BITS) : '0;
        end
        MM_POW_POW: pow_mem[{cpi_r, cpj_r}] <= cp_r;
        default: acc_mem[{cpi_r, cpj_r}] <= cp_r;
      endcase
    end
  end

  assign sts.done = done_r;
endmodule

FILE: design/matrix_power_vector_product.sv
// Load words (matrix entry, vector element) are taken one per cycle while in_ch.ready is high.
// A start word holds in_ch.ready low until the last output row is taken: an init copy, then
// P = popcount(M) + floor(log2(M)) matrix products (0 for M = 0), then the vector product,
// with one MAC per cycle while output backpressure does not stall the pipeline.
// Output rows come out in row order; output stalls hold the vector product pipeline.
// Synchronous active-low reset clears control and sets size to 1; matrices and vector are
// undefined until written.
module matrix_power_vector_product #(
  parameter int MAX_DIM   = mpvp_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mpvp_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mpvp_in_if.sink     in_ch,
  mpvp_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mpvp_pkg::*;

  logic [5:0] size_r;
  mpvp_cmd_t  cmd;
  mpvp_sts_t  sts;
  logic       busy, acc;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {26'd0, size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 6'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 3'd0)
      size_r <= cfg_pwdata[5:0];
  end

  assign in_ch.ready = !busy;
  assign acc = in_ch.valid && in_ch.ready;

  mpvp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .start(acc && in_ch.operation == OP_START),
    .exponent(in_ch.exponent),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  mpvp_dp #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .wr_mat(acc && in_ch.operation == OP_MAT),
    .wr_vec(acc && in_ch.operation == OP_VEC),
    .wr_row(in_ch.row_index), .wr_col(in_ch.col_index), .wr_val(in_ch.value),
    .size(size_r), .cmd(cmd), .sts(sts),
    .o_valid(out_ch.valid), .o_ready(out_ch.ready),
    .o_row(out_ch.row_index_res), .o_val(out_ch.result_value), .o_last(out_ch.last)
  );
endmodule
